FILE: rtl/aimang_pkg.sv
// ----------------------------------------------------------------------------
// aimang_pkg
// Shared constants for the aim-angle converter: field widths, internal
// datapath widths and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package aimang_pkg;

   localparam int COORD_WIDTH_DEF = 16;

   // Result field widths.
   localparam int ANGLE_W     = 15;
   localparam int RANGE_W     = 16;
   localparam int ANGLE_LIMIT = 9000;

   // Square-root datapath: 64-bit radicand, 32-bit root.
   localparam int SQ_W   = 64;
   localparam int REM_W  = SQ_W + 1;
   localparam int ROOT_W = SQ_W / 2;

   // CORDIC operands before and after normalization.
   localparam int OP_W        = 34;
   localparam int NORM_W      = 41;
   localparam int NORM_STEPS  = 6;
   localparam int CX_W        = 44;
   localparam int ACC_W       = 32;
   localparam int FRAC_BITS   = 16;
   localparam int CORDIC_STEPS = 28;

   // atan(2^-i) in units of 2^-16 centidegree.
   localparam logic signed [ACC_W-1:0] ATAN_TAB [CORDIC_STEPS] = '{
      32'sd294912000, 32'sd174096719, 32'sd91987925, 32'sd46694507,
      32'sd23437865,  32'sd11730358,  32'sd5866610,  32'sd2933484,
      32'sd1466764,   32'sd733389,    32'sd366693,   32'sd183346,
      32'sd91673,     32'sd45837,     32'sd22918,    32'sd11459,
      32'sd5730,      32'sd2865,      32'sd1432,     32'sd716,
      32'sd358,       32'sd179,       32'sd90,       32'sd45,
      32'sd22,        32'sd11,        32'sd6,        32'sd3
   };

endpackage

FILE: rtl/aimang_channels.sv
// ----------------------------------------------------------------------------
// aimang channels
// Valid/ready channels that carry a target translation in and the aiming
// angles and range out.
// ----------------------------------------------------------------------------
interface aimang_req_if #(
   parameter int COORD_WIDTH = aimang_pkg::COORD_WIDTH_DEF
);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] pos_x;
   logic signed [COORD_WIDTH-1:0] pos_y;
   logic signed [COORD_WIDTH-1:0] pos_z;

   modport source (output valid, output pos_x, output pos_y, output pos_z, input ready);
   modport sink   (input valid, input pos_x, input pos_y, input pos_z, output ready);
endinterface

interface aimang_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [aimang_pkg::ANGLE_W-1:0] yaw_centideg;
   logic signed [aimang_pkg::ANGLE_W-1:0] pitch_centideg;
   logic [aimang_pkg::RANGE_W-1:0]        range_mm;
   logic                                  degenerate;

   modport source (output valid, output yaw_centideg, output pitch_centideg,
                   output range_mm, output degenerate, input ready);
   modport sink   (input valid, input yaw_centideg, input pitch_centideg,
                   input range_mm, input degenerate, output ready);
endinterface

FILE: rtl/aim_angles_from_translation_core.sv
// ----------------------------------------------------------------------------
// aim_angles_from_translation_core
// Converts a camera-frame translation into yaw, pitch and range with
// pipelined square roots and two pipelined vectoring CORDICs.
// ----------------------------------------------------------------------------
// Usage:
//   req_bus carries one target translation (pos_x, pos_y, pos_z, signed mm)
//   per item; rsp_bus returns yaw and pitch in centidegrees, the truncated
//   range in mm, saturated at all ones, and a degenerate flag when x and z
//   are both zero.
//   Three front stages form absolute values, squares and sums, 33 stages load
//   the radicands and resolve the two square roots one root bit each, 7 stages
//   normalize the CORDIC operands, 29 stages run the 28 CORDIC iterations and
//   one stage rounds and registers the result. Every stage holds its own
//   valid bit; throughput is one item per cycle while no result is stalled.
//   When the receiver stalls with a result waiting, the whole pipeline
//   freezes and req_bus.ready drops in the same cycle, so no item is lost or
//   repeated. Reset clears all valid bits; the pipeline is empty afterwards.
// ----------------------------------------------------------------------------
module aim_angles_from_translation_core #(
   parameter int COORD_WIDTH = aimang_pkg::COORD_WIDTH_DEF
) (
   input logic         clock,
   input logic         reset,
   aimang_req_if.sink  req_bus,
   aimang_rsp_if.source rsp_bus
);
   import aimang_pkg::*;

   localparam int HSHIFT = (COORD_WIDTH < 31) ? 31 - COORD_WIDTH : 0;

   typedef struct packed {
      logic x_pos;
      logic x_neg;
      logic z_neg;
      logic y_pos;
      logic ax_zero;
      logic az_zero;
      logic ay_zero;
   } flags_type;

   typedef struct packed {
      flags_type       fl;
      logic [OP_W-1:0] yaw_num;
      logic [OP_W-1:0] yaw_den;
      logic [OP_W-1:0] pitch_num;
   } carry_type;

   typedef struct packed {
      carry_type         cr;
      logic [REM_W-1:0]  drem;
      logic [ROOT_W-1:0] droot;
      logic [REM_W-1:0]  hrem;
      logic [ROOT_W-1:0] hroot;
   } sq_type;

   typedef struct packed {
      flags_type         fl;
      logic [NORM_W-1:0] ynum;
      logic [NORM_W-1:0] yden;
      logic [NORM_W-1:0] pnum;
      logic [NORM_W-1:0] pden;
      logic [ROOT_W-1:0] rng;
   } nm_type;

   typedef struct packed {
      flags_type               fl;
      logic signed [CX_W-1:0]  ycx;
      logic signed [CX_W-1:0]  ycy;
      logic signed [CX_W-1:0]  pcx;
      logic signed [CX_W-1:0]  pcy;
      logic signed [ACC_W-1:0] yacc;
      logic signed [ACC_W-1:0] pacc;
      logic [ROOT_W-1:0]       rng;
   } cd_type;

   // Rounded, limited angle magnitude from the CORDIC accumulator.
   function automatic logic [ANGLE_W-1:0] round_mag(input logic signed [ACC_W-1:0] acc);
      logic [ACC_W:0]           sum;
      logic [ACC_W-FRAC_BITS:0] q;
      sum = {1'b0, acc} + (ACC_W+1)'(1 << (FRAC_BITS - 1));
      q   = sum[ACC_W:FRAC_BITS];
      if (acc[ACC_W-1]) begin
         return '0;
      end
      if (q > (ACC_W-FRAC_BITS+1)'(ANGLE_LIMIT)) begin
         return ANGLE_W'(ANGLE_LIMIT);
      end
      return q[ANGLE_W-1:0];
   endfunction

   logic adv;
   logic out_vld_ff;

   assign adv           = !out_vld_ff || rsp_bus.ready;
   assign req_bus.ready = adv;

   // ---------------- front stages ----------------
   logic                   p1_vld_ff, p2_vld_ff, p3_vld_ff;
   logic [COORD_WIDTH-1:0] ax_in, ay_in, az_in;
   logic [COORD_WIDTH-1:0] p1_ax_ff, p1_ay_ff, p1_az_ff;
   flags_type              fl_in;
   carry_type              p1_cr_ff, p2_cr_ff, p3_cr_ff;
   logic [2*COORD_WIDTH-1:0] p2_axsq_ff, p2_aysq_ff, p2_azsq_ff, p3_aysq_ff;
   logic [SQ_W-1:0]        p3_hsq_ff;

   assign ax_in = req_bus.pos_x[COORD_WIDTH-1] ? (~req_bus.pos_x + 1'b1) : req_bus.pos_x;
   assign ay_in = req_bus.pos_y[COORD_WIDTH-1] ? (~req_bus.pos_y + 1'b1) : req_bus.pos_y;
   assign az_in = req_bus.pos_z[COORD_WIDTH-1] ? (~req_bus.pos_z + 1'b1) : req_bus.pos_z;

   always_comb begin
      fl_in.x_neg   = req_bus.pos_x[COORD_WIDTH-1];
      fl_in.ax_zero = (ax_in == '0);
      fl_in.x_pos   = !fl_in.x_neg && !fl_in.ax_zero;
      fl_in.z_neg   = req_bus.pos_z[COORD_WIDTH-1];
      fl_in.az_zero = (az_in == '0);
      fl_in.ay_zero = (ay_in == '0);
      fl_in.y_pos   = !req_bus.pos_y[COORD_WIDTH-1] && !fl_in.ay_zero;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_vld_ff <= 1'b0;
         p2_vld_ff <= 1'b0;
         p3_vld_ff <= 1'b0;
      end else if (adv) begin
         p1_vld_ff <= req_bus.valid;
         p2_vld_ff <= p1_vld_ff;
         p3_vld_ff <= p2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p1_ax_ff <= ax_in;
         p1_ay_ff <= ay_in;
         p1_az_ff <= az_in;
         p1_cr_ff.fl        <= fl_in;
         p1_cr_ff.yaw_num   <= OP_W'(ax_in);
         p1_cr_ff.yaw_den   <= OP_W'(az_in);
         p1_cr_ff.pitch_num <= OP_W'(ay_in) << HSHIFT;
         p2_axsq_ff <= p1_ax_ff * p1_ax_ff;
         p2_aysq_ff <= p1_ay_ff * p1_ay_ff;
         p2_azsq_ff <= p1_az_ff * p1_az_ff;
         p2_cr_ff   <= p1_cr_ff;
         p3_hsq_ff  <= SQ_W'(p2_axsq_ff) + SQ_W'(p2_azsq_ff);
         p3_aysq_ff <= p2_aysq_ff;
         p3_cr_ff   <= p2_cr_ff;
      end
   end

   // ---------------- square roots, one root bit per stage ----------------
   sq_type sq_ff     [ROOT_W+1];
   logic   sq_vld_ff [ROOT_W+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_vld_ff[0] <= 1'b0;
      end else if (adv) begin
         sq_vld_ff[0] <= p3_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sq_ff[0].cr    <= p3_cr_ff;
         sq_ff[0].drem  <= REM_W'(p3_hsq_ff + SQ_W'(p3_aysq_ff));
         sq_ff[0].droot <= '0;
         sq_ff[0].hrem  <= REM_W'(p3_hsq_ff << (2 * HSHIFT));
         sq_ff[0].hroot <= '0;
      end
   end

   for (genvar k = 1; k <= ROOT_W; k++) begin : g_sqrt
      localparam int B = ROOT_W - k;
      logic [REM_W-1:0] dtrial, htrial;
      sq_type           nxt;

      always_comb begin
         nxt    = sq_ff[k-1];
         dtrial = (REM_W'(sq_ff[k-1].droot) << (B + 1)) | (REM_W'(1) << (2 * B));
         htrial = (REM_W'(sq_ff[k-1].hroot) << (B + 1)) | (REM_W'(1) << (2 * B));
         if (sq_ff[k-1].drem >= dtrial) begin
            nxt.drem     = sq_ff[k-1].drem - dtrial;
            nxt.droot[B] = 1'b1;
         end
         if (sq_ff[k-1].hrem >= htrial) begin
            nxt.hrem     = sq_ff[k-1].hrem - htrial;
            nxt.hroot[B] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            sq_vld_ff[k] <= 1'b0;
         end else if (adv) begin
            sq_vld_ff[k] <= sq_vld_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            sq_ff[k] <= nxt;
         end
      end
   end

   // ---------------- operand normalization ----------------
   // Both operands of each arctangent move left together until the larger
   // one reaches 2^40, by shifts of 32, 16, 8, 4, 2 and 1.
   nm_type nm_ff     [NORM_STEPS+1];
   logic   nm_vld_ff [NORM_STEPS+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         nm_vld_ff[0] <= 1'b0;
      end else if (adv) begin
         nm_vld_ff[0] <= sq_vld_ff[ROOT_W];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         nm_ff[0].fl   <= sq_ff[ROOT_W].cr.fl;
         nm_ff[0].ynum <= NORM_W'(sq_ff[ROOT_W].cr.yaw_num);
         nm_ff[0].yden <= NORM_W'(sq_ff[ROOT_W].cr.yaw_den);
         nm_ff[0].pnum <= NORM_W'(sq_ff[ROOT_W].cr.pitch_num);
         nm_ff[0].pden <= NORM_W'(sq_ff[ROOT_W].hroot);
         nm_ff[0].rng  <= sq_ff[ROOT_W].droot;
      end
   end

   for (genvar j = 1; j <= NORM_STEPS; j++) begin : g_norm
      localparam int S = 1 << (NORM_STEPS - j);
      nm_type nxt;

      always_comb begin
         nxt = nm_ff[j-1];
         if (((nm_ff[j-1].ynum | nm_ff[j-1].yden) >> (NORM_W - S)) == '0) begin
            nxt.ynum = nm_ff[j-1].ynum << S;
            nxt.yden = nm_ff[j-1].yden << S;
         end
         if (((nm_ff[j-1].pnum | nm_ff[j-1].pden) >> (NORM_W - S)) == '0) begin
            nxt.pnum = nm_ff[j-1].pnum << S;
            nxt.pden = nm_ff[j-1].pden << S;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            nm_vld_ff[j] <= 1'b0;
         end else if (adv) begin
            nm_vld_ff[j] <= nm_vld_ff[j-1];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            nm_ff[j] <= nxt;
         end
      end
   end

   // ---------------- vectoring CORDIC, one iteration per stage ----------------
   cd_type cd_ff     [CORDIC_STEPS+1];
   logic   cd_vld_ff [CORDIC_STEPS+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         cd_vld_ff[0] <= 1'b0;
      end else if (adv) begin
         cd_vld_ff[0] <= nm_vld_ff[NORM_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cd_ff[0].fl   <= nm_ff[NORM_STEPS].fl;
         cd_ff[0].ycx  <= CX_W'(nm_ff[NORM_STEPS].yden);
         cd_ff[0].ycy  <= CX_W'(nm_ff[NORM_STEPS].ynum);
         cd_ff[0].pcx  <= CX_W'(nm_ff[NORM_STEPS].pden);
         cd_ff[0].pcy  <= CX_W'(nm_ff[NORM_STEPS].pnum);
         cd_ff[0].yacc <= '0;
         cd_ff[0].pacc <= '0;
         cd_ff[0].rng  <= nm_ff[NORM_STEPS].rng;
      end
   end

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
      logic signed [CX_W-1:0] ycx, ycy, pcx, pcy;
      cd_type                 nxt;

      always_comb begin
         ycx = cd_ff[i].ycx;
         ycy = cd_ff[i].ycy;
         pcx = cd_ff[i].pcx;
         pcy = cd_ff[i].pcy;
         nxt = cd_ff[i];
         // Rotate toward the x axis; a zero y rotates the negative way.
         if (!ycy[CX_W-1] && (ycy != '0)) begin
            nxt.ycx  = ycx + (ycy >>> i);
            nxt.ycy  = ycy - (ycx >>> i);
            nxt.yacc = cd_ff[i].yacc + ATAN_TAB[i];
         end else begin
            nxt.ycx  = ycx - (ycy >>> i);
            nxt.ycy  = ycy + (ycx >>> i);
            nxt.yacc = cd_ff[i].yacc - ATAN_TAB[i];
         end
         if (!pcy[CX_W-1] && (pcy != '0)) begin
            nxt.pcx  = pcx + (pcy >>> i);
            nxt.pcy  = pcy - (pcx >>> i);
            nxt.pacc = cd_ff[i].pacc + ATAN_TAB[i];
         end else begin
            nxt.pcx  = pcx - (pcy >>> i);
            nxt.pcy  = pcy + (pcx >>> i);
            nxt.pacc = cd_ff[i].pacc - ATAN_TAB[i];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            cd_vld_ff[i+1] <= 1'b0;
         end else if (adv) begin
            cd_vld_ff[i+1] <= cd_vld_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            cd_ff[i+1] <= nxt;
         end
      end
   end

   // ---------------- result selection and output register ----------------
   flags_type          fl_last;
   logic [ANGLE_W-1:0] ymag, pmag, yaw_in, pitch_in;
   logic [RANGE_W-1:0] range_in;
   logic               degen_in;

   assign fl_last = cd_ff[CORDIC_STEPS].fl;
   assign ymag    = round_mag(cd_ff[CORDIC_STEPS].yacc);
   assign pmag    = round_mag(cd_ff[CORDIC_STEPS].pacc);

   always_comb begin
      degen_in = 1'b0;
      if (fl_last.ax_zero && fl_last.az_zero) begin
         // Target on the vertical axis: yaw is undefined.
         degen_in = 1'b1;
         yaw_in   = '0;
         if (fl_last.ay_zero) begin
            pitch_in = '0;
         end else if (fl_last.y_pos) begin
            pitch_in = -ANGLE_W'(ANGLE_LIMIT);
         end else begin
            pitch_in = ANGLE_W'(ANGLE_LIMIT);
         end
      end else begin
         if (fl_last.az_zero) begin
            yaw_in = fl_last.x_pos ? ANGLE_W'(ANGLE_LIMIT) : -ANGLE_W'(ANGLE_LIMIT);
         end else if (fl_last.ax_zero) begin
            yaw_in = '0;
         end else if (fl_last.x_neg != fl_last.z_neg) begin
            yaw_in = -ymag;
         end else begin
            yaw_in = ymag;
         end
         if (fl_last.ay_zero) begin
            pitch_in = '0;
         end else if (fl_last.y_pos) begin
            pitch_in = -pmag;
         end else begin
            pitch_in = pmag;
         end
      end
      if (cd_ff[CORDIC_STEPS].rng[ROOT_W-1:RANGE_W] != '0) begin
         range_in = '1;
      end else begin
         range_in = cd_ff[CORDIC_STEPS].rng[RANGE_W-1:0];
      end
   end

   logic [ANGLE_W-1:0] yaw_ff, pitch_ff;
   logic [RANGE_W-1:0] range_ff;
   logic               degen_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         out_vld_ff <= cd_vld_ff[CORDIC_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         yaw_ff   <= yaw_in;
         pitch_ff <= pitch_in;
         range_ff <= range_in;
         degen_ff <= degen_in;
      end
   end

   assign rsp_bus.valid          = out_vld_ff;
   assign rsp_bus.yaw_centideg   = yaw_ff;
   assign rsp_bus.pitch_centideg = pitch_ff;
   assign rsp_bus.range_mm       = range_ff;
   assign rsp_bus.degenerate     = degen_ff;

   // ---------------- assertions ----------------
   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (out_vld_ff && !rsp_bus.ready) |-> !req_bus.ready)
      else $error("input taken while a result is stalled");

   a_reset_empties: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> !rsp_bus.valid)
      else $error("result valid right after reset");

   a_degen_yaw_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.degenerate) |-> (rsp_bus.yaw_centideg == '0))
      else $error("degenerate item with nonzero yaw");

   a_angle_limits: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> ((rsp_bus.yaw_centideg <= ANGLE_W'(ANGLE_LIMIT))
                         && (rsp_bus.yaw_centideg >= -ANGLE_W'(ANGLE_LIMIT))
                         && (rsp_bus.pitch_centideg <= ANGLE_W'(ANGLE_LIMIT))
                         && (rsp_bus.pitch_centideg >= -ANGLE_W'(ANGLE_LIMIT))))
      else $error("angle outside limits");

endmodule
